// File: rtl/core/fcr_pkg.sv
// Shared types and constants for the filled circle rasterizer.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
`timescale 1ns / 1ps

package fcr_pkg;

   // Radius register keeps only this many low bits.
   localparam int RADIUS_BITS = 9;

   localparam int RAD_W      = 9;
   localparam int CENTER_W   = 10;
   localparam int ROFF_W     = 10;
   localparam int COORD_W    = 12;
   localparam int CODE_W     = 8;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int SQ_W       = 2 * RAD_W;
   localparam int SPAN_CNT_W = $clog2(RAD_W);
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

   localparam logic [RAD_W-1:0]  RADIUS_MASK    = RAD_W'((1 << RADIUS_BITS) - 1);
   localparam logic [CODE_W-1:0] FILL_CODE_INIT = CODE_W'(35);

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_ROW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_COL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_CODE  = 2'd3;

   typedef enum logic {
      OP_ADVANCE = 1'b0,
      OP_RESTART = 1'b1
   } op_type;

   typedef struct packed {
      logic [CENTER_W-1:0] center_row;
      logic [CENTER_W-1:0] center_col;
      logic [RAD_W-1:0]    radius;
      logic [CODE_W-1:0]   fill_code;
   } cfg_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } q_head_type;

   typedef struct packed {
      logic             start;
      logic [RAD_W-1:0] radius;
      logic [RAD_W-1:0] x;
   } span_req_type;

   typedef struct packed {
      logic             busy;
      logic             valid;
      logic [RAD_W-1:0] y;
      logic [RAD_W-1:0] radius;
      logic [RAD_W-1:0] x;
   } span_rsp_type;

endpackage

// File: rtl/core/fcr_front.sv
// Front end: accepts request transactions, classifies them and queues them.
// Depends on fcr_pkg.
`timescale 1ns / 1ps

module fcr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_restart,
   input  logic                pop,
   output fcr_pkg::q_head_type head
);

   fcr_pkg::op_type                 op_mem [fcr_pkg::Q_DEPTH];
   logic [fcr_pkg::Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [fcr_pkg::Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [fcr_pkg::Q_CNT_W-1:0]     count_ff, count_in;
   logic                            push;
   logic                            pop_ok;
   fcr_pkg::op_type                 op_class;

   assign req_ready = (count_ff < fcr_pkg::Q_CNT_W'(fcr_pkg::Q_DEPTH));
   assign push      = req_valid && req_ready;
   assign pop_ok    = pop && (count_ff != '0);
   assign op_class  = req_restart ? fcr_pkg::OP_RESTART : fcr_pkg::OP_ADVANCE;

   assign head.valid = (count_ff != '0);
   assign head.op    = op_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push, pop_ok})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_mem[wr_ptr_ff] <= op_class;
      end
   end

endmodule

// File: rtl/core/fcr_span.sv
// Half span unit: y = floor(sqrt(radius^2 - x^2)), two radicand bits per cycle.
// Depends on fcr_pkg.
`timescale 1ns / 1ps

module fcr_span (
   input  logic                  clock,
   input  logic                  reset,
   input  fcr_pkg::span_req_type req,
   output fcr_pkg::span_rsp_type rsp
);

   typedef enum logic [3:0] {
      SP_IDLE = 4'b0001,
      SP_MUL  = 4'b0010,
      SP_SUB  = 4'b0100,
      SP_ITER = 4'b1000
   } span_state_type;

   span_state_type                   state_ff, state_in;
   logic                             vld_ff, vld_in;
   logic [fcr_pkg::RAD_W-1:0]        r_ff, r_in;
   logic [fcr_pkg::RAD_W-1:0]        x_ff, x_in;
   logic [fcr_pkg::SQ_W-1:0]         r2_ff, r2_in;
   logic [fcr_pkg::SQ_W-1:0]         x2_ff, x2_in;
   logic [fcr_pkg::SQ_W-1:0]         v_ff, v_in;
   logic [fcr_pkg::RAD_W+1:0]        rem_ff, rem_in;
   logic [fcr_pkg::RAD_W-1:0]        root_ff, root_in;
   logic [fcr_pkg::SPAN_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [fcr_pkg::RAD_W+1:0]        rem_sh;
   logic [fcr_pkg::RAD_W+1:0]        trial;

   assign rsp.busy   = (state_ff != SP_IDLE);
   assign rsp.valid  = vld_ff;
   assign rsp.y      = root_ff;
   assign rsp.radius = r_ff;
   assign rsp.x      = x_ff;

   assign rem_sh = {rem_ff[fcr_pkg::RAD_W-1:0], v_ff[fcr_pkg::SQ_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};

   always_comb begin
      state_in = state_ff;
      vld_in   = vld_ff;
      r_in     = r_ff;
      x_in     = x_ff;
      r2_in    = r2_ff;
      x2_in    = x2_ff;
      v_in     = v_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         SP_IDLE: begin
            if (req.start) begin
               r_in     = req.radius;
               x_in     = req.x;
               vld_in   = 1'b0;
               state_in = SP_MUL;
            end
         end
         SP_MUL: begin
            r2_in    = fcr_pkg::SQ_W'(r_ff) * fcr_pkg::SQ_W'(r_ff);
            x2_in    = fcr_pkg::SQ_W'(x_ff) * fcr_pkg::SQ_W'(x_ff);
            state_in = SP_SUB;
         end
         SP_SUB: begin
            v_in     = (r2_ff > x2_ff) ? (r2_ff - x2_ff) : '0;
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = fcr_pkg::SPAN_CNT_W'(fcr_pkg::RAD_W - 1);
            state_in = SP_ITER;
         end
         SP_ITER: begin
            // one root bit per cycle, restoring form
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[fcr_pkg::RAD_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[fcr_pkg::RAD_W-2:0], 1'b0};
            end
            v_in   = {v_ff[fcr_pkg::SQ_W-3:0], 2'b00};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               vld_in   = 1'b1;
               state_in = SP_IDLE;
            end
         end
         default: begin
            vld_in   = 1'b0;
            state_in = SP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SP_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff    <= r_in;
      x_ff    <= x_in;
      r2_ff   <= r2_in;
      x2_ff   <= x2_in;
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// File: rtl/core/fcr_engine.sv
// Back end: walks the circle cell by cell and drives the response register.
// Depends on fcr_pkg; takes half spans from fcr_span and transactions from fcr_front.
`timescale 1ns / 1ps

module fcr_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  fcr_pkg::cfg_type              cfg,
   input  fcr_pkg::q_head_type           head,
   output logic                          pop,
   output fcr_pkg::span_req_type         span_req,
   input  fcr_pkg::span_rsp_type         span_rsp,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fcr_pkg::COORD_W-1:0]   row_out,
   output logic [fcr_pkg::COORD_W-1:0]   col_out,
   output logic [fcr_pkg::CODE_W-1:0]    code_out,
   output logic                          last_out
);

   logic [fcr_pkg::RAD_W-1:0]    x_ff, x_in;
   logic [fcr_pkg::RAD_W-1:0]    y_ff, y_in;
   logic [fcr_pkg::ROFF_W-1:0]   j_ff, j_in;
   logic                         m_ff, m_in;
   logic                         act_ff, act_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fcr_pkg::COORD_W-1:0]  row_ff, row_in;
   logic [fcr_pkg::COORD_W-1:0]  col_ff, col_in;
   logic [fcr_pkg::CODE_W-1:0]   code_ff, code_in;
   logic                         last_ff, last_in;

   logic                         is_restart;
   logic [fcr_pkg::ROFF_W:0]     j_inc;
   logic [fcr_pkg::ROFF_W:0]     two_y;
   logic [fcr_pkg::RAD_W:0]      x_inc;
   logic [fcr_pkg::RAD_W:0]      r_ext;
   logic [fcr_pkg::RAD_W-1:0]    x_next;
   logic                         col_step;
   logic                         col_end;
   logic                         span_hit;
   logic                         need_span;
   logic                         out_free;
   logic                         go;
   logic                         emit;

   assign is_restart = (head.op == fcr_pkg::OP_RESTART);
   assign j_inc      = {1'b0, j_ff} + 1'b1;
   assign two_y      = {1'b0, y_ff, 1'b0};
   assign x_inc      = {1'b0, x_ff} + 1'b1;
   assign r_ext      = {1'b0, cfg.radius};
   assign x_next     = x_inc[fcr_pkg::RAD_W-1:0];
   assign col_step   = act_ff && m_ff && (j_inc >= two_y);
   assign col_end    = (x_inc >= r_ext);
   assign span_hit   = span_rsp.valid && (span_rsp.x == x_next) &&
                       (span_rsp.radius == cfg.radius);
   assign need_span  = !is_restart && col_step && !col_end;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign go         = head.valid && out_free && (!need_span || span_hit);
   assign pop        = go;

   // keep the span of the next column in flight while this one streams
   assign span_req.start  = act_ff && !span_rsp.busy && !span_hit;
   assign span_req.radius = cfg.radius;
   assign span_req.x      = x_next;

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      j_in   = j_ff;
      m_in   = m_ff;
      act_in = act_ff;
      emit   = 1'b0;
      if (go) begin
         if (is_restart) begin
            x_in = '0;
            j_in = '0;
            m_in = 1'b0;
            if (cfg.radius == '0) begin
               y_in   = '0;
               act_in = 1'b0;
            end else begin
               // sqrt(r*r) is r itself
               y_in   = cfg.radius;
               act_in = 1'b1;
               emit   = 1'b1;
            end
         end else if (act_ff) begin
            if (!m_ff) begin
               m_in = 1'b1;
            end else begin
               m_in = 1'b0;
               j_in = j_inc[fcr_pkg::ROFF_W-1:0];
               if (col_step) begin
                  j_in = '0;
                  x_in = x_next;
                  if (!col_end) begin
                     y_in = span_rsp.y;
                  end
               end
            end
            // stop once the column passes the radius or the span is empty
            if ((col_step && col_end) || ({1'b0, x_in} >= r_ext) || (y_in == '0)) begin
               act_in = 1'b0;
            end else begin
               emit = 1'b1;
            end
         end
      end
   end

   always_comb begin
      row_in  = fcr_pkg::COORD_W'(cfg.center_row) + fcr_pkg::COORD_W'(j_in) -
                fcr_pkg::COORD_W'(y_in);
      col_in  = m_in ? (fcr_pkg::COORD_W'(cfg.center_col) - fcr_pkg::COORD_W'(x_in))
                     : (fcr_pkg::COORD_W'(cfg.center_col) + fcr_pkg::COORD_W'(x_in));
      code_in = cfg.fill_code;
      last_in = m_in &&
                (({1'b0, x_in} + 1'b1) == r_ext) &&
                (({1'b0, j_in} + 1'b1) == {1'b0, y_in, 1'b0});
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff         <= '0;
         y_ff         <= '0;
         j_ff         <= '0;
         m_ff         <= 1'b0;
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x_ff         <= x_in;
         y_ff         <= y_in;
         j_ff         <= j_in;
         m_ff         <= m_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         code_ff <= code_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign row_out   = row_ff;
   assign col_out   = col_ff;
   assign code_out  = code_ff;
   assign last_out  = last_ff;

endmodule

// File: rtl/core/filled_circle_rasterizer.sv
// Top level of the filled circle rasterizer: configuration registers and wiring.
// Depends on fcr_pkg, fcr_front, fcr_span and fcr_engine.
`timescale 1ns / 1ps

// Usage:
//   Write center_row, center_col, radius and fill_code through the csr_ port
//   (one write per cycle at csr_write_en, no read-back), then send request
//   transactions on req_. A request with req_restart set starts the circle at
//   its first cell; each request without it advances one cell. Every request
//   yields zero or one response transaction on rsp_ with the cell coordinates,
//   the fill code and a flag on the final cell.
//   Requests wait in a two-entry queue ahead of the cell walker. A request is
//   taken from the queue and its cell registered in the response register, at
//   one per cycle along a span while rsp_ready holds. At the step to a new column
//   the walker waits for the half span of that column from a bit-serial square
//   root unit; that unit starts on the next column the cycle after a column
//   begins, so the wait only shows on columns of fewer than 13 cells (half spans
//   below 4), and after a restart that finds the unit still busy with an older
//   column. A stalled rsp_ready holds the response register; the queue fills and
//   then req_ready drops. Reset clears the queue, the response register and the
//   drawing state and loads the configuration register defaults.

module filled_circle_rasterizer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [fcr_pkg::COORD_W-1:0]   rsp_cell_row,
   output logic signed [fcr_pkg::COORD_W-1:0]   rsp_cell_col,
   output logic [fcr_pkg::CODE_W-1:0]           rsp_cell_code,
   output logic                                 rsp_last_cell,
   input  logic                                 csr_write_en,
   input  logic [fcr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fcr_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   fcr_pkg::cfg_type               cfg_ff, cfg_in;
   fcr_pkg::q_head_type            head;
   fcr_pkg::span_req_type          span_req;
   fcr_pkg::span_rsp_type          span_rsp;
   logic                           pop;
   logic [fcr_pkg::COORD_W-1:0]    row_out;
   logic [fcr_pkg::COORD_W-1:0]    col_out;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            fcr_pkg::CSR_CENTER_ROW: cfg_in.center_row = csr_wdata[fcr_pkg::CENTER_W-1:0];
            fcr_pkg::CSR_CENTER_COL: cfg_in.center_col = csr_wdata[fcr_pkg::CENTER_W-1:0];
            fcr_pkg::CSR_RADIUS:
               cfg_in.radius = csr_wdata[fcr_pkg::RAD_W-1:0] & fcr_pkg::RADIUS_MASK;
            fcr_pkg::CSR_FILL_CODE:  cfg_in.fill_code = csr_wdata[fcr_pkg::CODE_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_row <= '0;
         cfg_ff.center_col <= '0;
         cfg_ff.radius     <= '0;
         cfg_ff.fill_code  <= fcr_pkg::FILL_CODE_INIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fcr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .pop         (pop),
      .head        (head)
   );

   fcr_span u_span (
      .clock (clock),
      .reset (reset),
      .req   (span_req),
      .rsp   (span_rsp)
   );

   fcr_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .pop       (pop),
      .span_req  (span_req),
      .span_rsp  (span_rsp),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .row_out   (row_out),
      .col_out   (col_out),
      .code_out  (rsp_cell_code),
      .last_out  (rsp_last_cell)
   );

   assign rsp_cell_row = $signed(row_out);
   assign rsp_cell_col = $signed(col_out);

endmodule

// File: rtl/core/fcr_checker.sv
// Port-level checks for filled_circle_rasterizer, attached with a bind.
// Depends on fcr_pkg and the top level's port list.
`timescale 1ns / 1ps

module fcr_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [fcr_pkg::COORD_W-1:0]   rsp_cell_row,
   input logic signed [fcr_pkg::COORD_W-1:0]   rsp_cell_col,
   input logic [fcr_pkg::CODE_W-1:0]           rsp_cell_code,
   input logic                                 rsp_last_cell,
   input logic                                 csr_write_en,
   input logic [fcr_pkg::CSR_IDX_W-1:0]        csr_index,
   input logic [fcr_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic [fcr_pkg::CODE_W-1:0] fill_ff;
   logic                       rzero_ff;

   // track the fill code and a zero radius as seen on the csr port
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= fcr_pkg::FILL_CODE_INIT;
         rzero_ff <= 1'b1;
      end else if (csr_write_en) begin
         if (csr_index == fcr_pkg::CSR_FILL_CODE) begin
            fill_ff <= csr_wdata[fcr_pkg::CODE_W-1:0];
         end
         if (csr_index == fcr_pkg::CSR_RADIUS) begin
            rzero_ff <= ((csr_wdata[fcr_pkg::RAD_W-1:0] & fcr_pkg::RADIUS_MASK) == '0);
         end
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_row) &&
      $stable(rsp_cell_col) && $stable(rsp_cell_code) && $stable(rsp_last_cell))
      else $error("stalled response changed");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$rose(rsp_valid) |-> $stable(rsp_cell_code) || $past(rsp_ready))
      else $error("response code changed without a handshake");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && !$past(csr_write_en) |-> rsp_cell_code == fill_ff)
      else $error("cell code differs from the fill code register");

   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      rzero_ff && !rsp_valid |=> !rsp_valid)
      else $error("cell drawn with a zero radius");

endmodule

bind filled_circle_rasterizer fcr_checker u_fcr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_cell_row  (rsp_cell_row),
   .rsp_cell_col  (rsp_cell_col),
   .rsp_cell_code (rsp_cell_code),
   .rsp_last_cell (rsp_last_cell),
   .csr_write_en  (csr_write_en),
   .csr_index     (csr_index),
   .csr_wdata     (csr_wdata)
);

// File: bench/filled_circle_rasterizer_tb.sv
// Self-checking bench for filled_circle_rasterizer: directed script, then random circles.
// Cells are predicted by a behavioral span walker in this file; uses fcr_pkg for types.
`timescale 1ns / 1ps

module filled_circle_rasterizer_tb;

   localparam int    RANDOM_ITEMS  = 1450;
   localparam int    SETTLE_CYCLES = 40;
   localparam int    DRAW_CAP      = 260;
   localparam real   HALF_PERIOD   = 6.0;
   localparam longint TIMEOUT_NS   = 4_000_000;

   typedef struct packed {
      logic [fcr_pkg::COORD_W-1:0] row;
      logic [fcr_pkg::COORD_W-1:0] col;
      logic [fcr_pkg::CODE_W-1:0]  code;
      logic                        last;
   } cell_type;

   typedef enum {ROW_WRITE, ROW_SEND} row_kind_type;

   typedef struct {
      row_kind_type                   kind;
      logic [fcr_pkg::CSR_IDX_W-1:0]  idx;
      logic [fcr_pkg::CSR_DATA_W-1:0] data;
      fcr_pkg::op_type                op;
      bit                             fixed;
      bit                             fixed_gives;
      cell_type                       fixed_cell;
   } step_row_type;

   logic                                clock        = 1'b0;
   logic                                reset        = 1'b1;
   logic                                req_valid    = 1'b0;
   logic                                req_ready;
   logic                                req_restart  = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready    = 1'b0;
   logic signed [fcr_pkg::COORD_W-1:0]  rsp_cell_row;
   logic signed [fcr_pkg::COORD_W-1:0]  rsp_cell_col;
   logic [fcr_pkg::CODE_W-1:0]          rsp_cell_code;
   logic                                rsp_last_cell;
   logic                                csr_write_en = 1'b0;
   logic [fcr_pkg::CSR_IDX_W-1:0]       csr_index    = '0;
   logic [fcr_pkg::CSR_DATA_W-1:0]      csr_wdata    = '0;

   // register copies and walker state of the predictor
   logic [fcr_pkg::CENTER_W-1:0] reg_center_row = '0;
   logic [fcr_pkg::CENTER_W-1:0] reg_center_col = '0;
   logic [fcr_pkg::RAD_W-1:0]    reg_radius     = '0;
   logic [fcr_pkg::CODE_W-1:0]   reg_fill       = fcr_pkg::FILL_CODE_INIT;
   logic [fcr_pkg::RAD_W-1:0]    walk_x         = '0;
   logic [fcr_pkg::RAD_W-1:0]    walk_span      = '0;
   logic [fcr_pkg::ROFF_W-1:0]   walk_j         = '0;
   logic                         walk_mirror    = 1'b0;
   logic                         walk_busy      = 1'b0;

   cell_type     cells_due[$];
   step_row_type script[$];
   int           mismatch_count = 0;
   int           items_done     = 0;
   int           req_idle_pct   = 0;
   int           rsp_idle_pct   = 0;

   filled_circle_rasterizer DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_row  (rsp_cell_row),
      .rsp_cell_col  (rsp_cell_col),
      .rsp_cell_code (rsp_cell_code),
      .rsp_last_cell (rsp_last_cell),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("%0t: mismatch: %s", $time, msg);
   endtask

   function automatic logic [fcr_pkg::RAD_W-1:0] half_span_at(input int unsigned r,
                                                              input int unsigned x);
      int unsigned area;
      int unsigned root;
      area = (r * r > x * x) ? r * r - x * x : 0;
      root = 0;
      while ((root + 1) * (root + 1) <= area) root++;
      return root[fcr_pkg::RAD_W-1:0];
   endfunction

   // Walk one cell along the spans; gives is low when the transaction yields no cell.
   task automatic trace_next_cell(input fcr_pkg::op_type op, output bit gives,
                                  output cell_type c);
      int coord;
      gives = 1'b0;
      c     = '0;
      if (op == fcr_pkg::OP_RESTART) begin
         walk_x      = '0;
         walk_j      = '0;
         walk_mirror = 1'b0;
         if (reg_radius == 0) begin
            walk_span = '0;
            walk_busy = 1'b0;
            return;
         end
         walk_span = half_span_at(reg_radius, 0);
         walk_busy = 1'b1;
      end else begin
         if (!walk_busy) return;
         if (!walk_mirror) begin
            walk_mirror = 1'b1;
         end else begin
            walk_mirror = 1'b0;
            walk_j++;
            if (walk_j >= 2 * walk_span) begin
               walk_j = '0;
               walk_x++;
               if (walk_x >= reg_radius) begin
                  walk_busy = 1'b0;
                  return;
               end
               // span is taken from the radius in force when the column begins
               walk_span = half_span_at(reg_radius, walk_x);
            end
         end
         if (walk_x >= reg_radius || walk_span == 0) begin
            walk_busy = 1'b0;
            return;
         end
      end
      coord  = int'(reg_center_row) + int'(walk_j) - int'(walk_span);
      c.row  = coord[fcr_pkg::COORD_W-1:0];
      coord  = walk_mirror ? int'(reg_center_col) - int'(walk_x)
                           : int'(reg_center_col) + int'(walk_x);
      c.col  = coord[fcr_pkg::COORD_W-1:0];
      c.code = reg_fill;
      c.last = (walk_x + 1 == reg_radius) && (walk_j + 1 == 2 * walk_span) && walk_mirror;
      gives  = 1'b1;
   endtask

   task automatic pick_idle_mode(input int mode);
      case (mode)
         0: begin
            req_idle_pct = 22;
            rsp_idle_pct = 72;
         end
         1: begin
            req_idle_pct = 72;
            rsp_idle_pct = 22;
         end
         default: begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
      endcase
   endtask

   // Drive one request transaction and queue the cell it should produce.
   task automatic send_request(input fcr_pkg::op_type op, input bit fixed = 1'b0,
                               input bit fixed_gives = 1'b0,
                               input cell_type fixed_cell = '0);
      bit       gives;
      cell_type c;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= op;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      trace_next_cell(op, gives, c);
      if (fixed) begin
         gives = fixed_gives;
         c     = fixed_cell;
      end
      if (gives) cells_due.push_back(c);
      if (op == fcr_pkg::OP_RESTART || gives) items_done++;
   endtask

   // Drop valid, wait for every cell due, then let the span unit go quiet.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (cells_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [fcr_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [fcr_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         fcr_pkg::CSR_CENTER_ROW: reg_center_row = data[fcr_pkg::CENTER_W-1:0];
         fcr_pkg::CSR_CENTER_COL: reg_center_col = data[fcr_pkg::CENTER_W-1:0];
         fcr_pkg::CSR_RADIUS:
            reg_radius = data[fcr_pkg::RAD_W-1:0] & fcr_pkg::RADIUS_MASK;
         fcr_pkg::CSR_FILL_CODE:  reg_fill       = data[fcr_pkg::CODE_W-1:0];
         default: ;
      endcase
   endtask

   function automatic step_row_type csr_row(input logic [fcr_pkg::CSR_IDX_W-1:0] idx,
                                            input logic [fcr_pkg::CSR_DATA_W-1:0] data);
      step_row_type s;
      s      = '{ROW_WRITE, idx, data, fcr_pkg::OP_ADVANCE, 1'b0, 1'b0, '0};
      return s;
   endfunction

   function automatic step_row_type req_row(input fcr_pkg::op_type op);
      step_row_type s;
      s = '{ROW_SEND, '0, '0, op, 1'b0, 1'b0, '0};
      return s;
   endfunction

   function automatic step_row_type fixed_row(input fcr_pkg::op_type op, input bit gives,
                                              input logic [fcr_pkg::COORD_W-1:0] row,
                                              input logic [fcr_pkg::COORD_W-1:0] col,
                                              input logic [fcr_pkg::CODE_W-1:0] code,
                                              input logic last);
      step_row_type s;
      s = '{ROW_SEND, '0, '0, op, 1'b1, gives, '{row, col, code, last}};
      return s;
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin : rsp_check
      cell_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cells_due.size() == 0) begin
            flag_mismatch($sformatf("cell (%0h, %0h) with none due", rsp_cell_row,
                                    rsp_cell_col));
         end else begin
            want = cells_due.pop_front();
            if (rsp_cell_row !== want.row)
               flag_mismatch($sformatf("cell_row %0h, expected %0h", rsp_cell_row, want.row));
            if (rsp_cell_col !== want.col)
               flag_mismatch($sformatf("cell_col %0h, expected %0h", rsp_cell_col, want.col));
            if (rsp_cell_code !== want.code)
               flag_mismatch($sformatf("cell_code %0h, expected %0h", rsp_cell_code,
                                       want.code));
            if (rsp_last_cell !== want.last)
               flag_mismatch($sformatf("last_cell %0b, expected %0b", rsp_last_cell,
                                       want.last));
         end
      end
   end

   initial begin : stimulus
      int roll;
      int budget;
      int n;

      script = '{
         fixed_row(fcr_pkg::OP_ADVANCE, 1'b0, '0, '0, '0, 1'b0),      // idle advance
         fixed_row(fcr_pkg::OP_RESTART, 1'b0, '0, '0, '0, 1'b0),      // zero radius
         csr_row(fcr_pkg::CSR_RADIUS, 10'd1),
         fixed_row(fcr_pkg::OP_RESTART, 1'b1, 12'hFFF, 12'h000, 8'd35, 1'b0),
         fixed_row(fcr_pkg::OP_ADVANCE, 1'b1, 12'hFFF, 12'h000, 8'd35, 1'b0),
         fixed_row(fcr_pkg::OP_ADVANCE, 1'b1, 12'h000, 12'h000, 8'd35, 1'b0),
         fixed_row(fcr_pkg::OP_ADVANCE, 1'b1, 12'h000, 12'h000, 8'd35, 1'b1),
         fixed_row(fcr_pkg::OP_ADVANCE, 1'b0, '0, '0, '0, 1'b0),      // past the final cell
         csr_row(fcr_pkg::CSR_CENTER_ROW, 10'h3FF),
         csr_row(fcr_pkg::CSR_CENTER_COL, 10'h3FF),
         csr_row(fcr_pkg::CSR_RADIUS, 10'h3FF),
         csr_row(fcr_pkg::CSR_FILL_CODE, 10'h3FF),
         fixed_row(fcr_pkg::OP_RESTART, 1'b1, 12'd512, 12'd1023, 8'd255, 1'b0),
         fixed_row(fcr_pkg::OP_ADVANCE, 1'b1, 12'd512, 12'd1023, 8'd255, 1'b0),
         fixed_row(fcr_pkg::OP_ADVANCE, 1'b1, 12'd513, 12'd1023, 8'd255, 1'b0),
         req_row(fcr_pkg::OP_ADVANCE),
         req_row(fcr_pkg::OP_ADVANCE),
         // move the center under a running circle: rows go negative
         csr_row(fcr_pkg::CSR_CENTER_ROW, 10'd0),
         csr_row(fcr_pkg::CSR_FILL_CODE, 10'h100),
         req_row(fcr_pkg::OP_ADVANCE),
         req_row(fcr_pkg::OP_ADVANCE),
         csr_row(fcr_pkg::CSR_RADIUS, 10'd2),
         fixed_row(fcr_pkg::OP_RESTART, 1'b1, 12'hFFE, 12'd1023, 8'd0, 1'b0),
         req_row(fcr_pkg::OP_ADVANCE),
         req_row(fcr_pkg::OP_ADVANCE),
         // shrink the radius to zero mid-circle: the drawing stops
         csr_row(fcr_pkg::CSR_RADIUS, 10'd0),
         fixed_row(fcr_pkg::OP_ADVANCE, 1'b0, '0, '0, '0, 1'b0),
         fixed_row(fcr_pkg::OP_ADVANCE, 1'b0, '0, '0, '0, 1'b0)
      };

      pick_idle_mode(0);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[k]) begin
         if (script[k].kind == ROW_WRITE) begin
            settle_block();
            write_register(script[k].idx, script[k].data);
         end else begin
            send_request(script[k].op, script[k].fixed, script[k].fixed_gives,
                         script[k].fixed_cell);
         end
      end

      while (items_done < RANDOM_ITEMS) begin
         pick_idle_mode(items_done * 3 / RANDOM_ITEMS);
         settle_block();
         if ($urandom_range(99) < 50) begin
            roll = $urandom_range(3);
            write_register(fcr_pkg::CSR_CENTER_ROW,
                           roll == 0 ? 10'd0 : roll == 1 ? 10'h3FF : 10'($urandom));
         end
         if ($urandom_range(99) < 50) begin
            roll = $urandom_range(3);
            write_register(fcr_pkg::CSR_CENTER_COL,
                           roll == 0 ? 10'd0 : roll == 1 ? 10'h3FF : 10'($urandom));
         end
         if ($urandom_range(99) < 70) begin
            // mostly small circles so they run to the final cell
            roll = $urandom_range(99);
            if (roll < 8)
               n = 0;
            else if (roll < 75)
               n = $urandom_range(6, 1);
            else if (roll < 92)
               n = $urandom_range(12, 7);
            else
               n = $urandom_range(511, 400);
            write_register(fcr_pkg::CSR_RADIUS, {1'($urandom), 9'(n)});
         end
         if ($urandom_range(99) < 40)
            write_register(fcr_pkg::CSR_FILL_CODE, 10'($urandom));

         roll = $urandom_range(99);
         if (roll < 78) begin
            send_request(fcr_pkg::OP_RESTART);
            budget = ($urandom_range(99) < 20) ? $urandom_range(30, 1) : DRAW_CAP;
            n = 0;
            while (walk_busy && n < budget) begin
               send_request(($urandom_range(199) == 0) ? fcr_pkg::OP_RESTART
                                                       : fcr_pkg::OP_ADVANCE);
               n++;
            end
            repeat ($urandom_range(2)) send_request(fcr_pkg::OP_ADVANCE);
         end else if (roll < 92) begin
            // resume whatever drawing is left, under the new registers
            repeat ($urandom_range(20, 1)) send_request(fcr_pkg::OP_ADVANCE);
         end else begin
            repeat ($urandom_range(10, 1))
               send_request(fcr_pkg::op_type'($urandom_range(1)));
         end
      end

      settle_block();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
